// ===== design/tefr_pkg.sv =====
// ----------------------------------------------------------------------------
// tefr_pkg: shared types and constants of the triangle rasterizer
// Field widths, configuration register indexes and the fixed-point widths
// used by the edge function datapath.
// ----------------------------------------------------------------------------
package tefr_pkg;

    // Beat field widths
    localparam int PIX_X_W    = 10;
    localparam int PIX_Y_W    = 9;
    localparam int ADDR_W     = 19;
    localparam int COLOR_W    = 32;

    // Configuration port
    localparam int VERT_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Screen dimensions are carried at this width (range 1 .. 2047)
    localparam int SCR_DIM_W  = 11;

    // Edge datapath: coordinate differences, products, edge values
    localparam int DIFF_W     = VERT_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int EDGE_W     = PROD_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_A_X = 3'd0,
        REG_VERTEX_A_Y = 3'd1,
        REG_VERTEX_B_X = 3'd2,
        REG_VERTEX_B_Y = 3'd3,
        REG_VERTEX_C_X = 3'd4,
        REG_VERTEX_C_Y = 3'd5,
        REG_FILL_COLOR = 3'd6
    } cfg_reg_t;

    typedef logic signed [VERT_W-1:0] vert_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [EDGE_W-1:0] edge_t;

    // Sign of an edge value: negative flag and nonzero flag
    typedef struct packed {
        logic neg;
        logic nz;
    } edge_sign_t;

endpackage

// ===== design/tefr_channels.sv =====
// ----------------------------------------------------------------------------
// tefr channels: valid/ready interfaces of the triangle rasterizer
// Configuration write channel, pixel input channel and result channel.
// ----------------------------------------------------------------------------
interface tefr_cfg_if;
    import tefr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface tefr_pixel_if;
    import tefr_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface tefr_result_if;
    import tefr_pkg::*;

    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, output write_enable, output pixel_address,
                    output pixel_color, input ready);
    modport sink   (input valid, input write_enable, input pixel_address,
                    input pixel_color, output ready);
endinterface

// ===== design/triangle_edge_function_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_function_rasterizer: half-space triangle coverage test
// Tests one raster pixel per beat against the triangle set by three signed
// vertices and emits a framebuffer write: enable, linear address, color.
// ----------------------------------------------------------------------------
//
//  channel  role    carries                                 handshake
//  -------  ------  --------------------------------------  -----------
//  cfg      sink    register index, write data              valid/ready
//  pixel    sink    pixel_x, pixel_y                        valid/ready
//  result   source  write_enable, pixel_address, color      valid/ready
//
// One beat in and one beat out per clock when result.ready stays high.
// Each beat passes the difference, multiply, edge sum and decision stages.
// The per-stage ready chain fills bubbles, so a stalled output only blocks
// input once all four stages hold a beat; a stall drops and repeats nothing.
// Reset clears the stage valid bits and all configuration registers to 0.
// The cfg channel is always ready; write it only while the pipeline is empty.
//
// Each edge P->Q is evaluated as F = (Qx-Px)*(y-Py) - (Qy-Py)*(x-Px), which
// is the negated edge function. The inside sign of every edge follows from
// the sign of the triangle orientation O = (b-a) x (c-a): edge a-b is inside
// where F has the sign of O, edges c-b and a-c where F has the opposite sign.
// A zero orientation (collinear vertices) or a zero F never draws.
// ----------------------------------------------------------------------------
module triangle_edge_function_rasterizer #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic          clk,
    input  logic          rst_n,
    tefr_cfg_if.sink      cfg,
    tefr_pixel_if.sink    pixel,
    tefr_result_if.source result
);
    import tefr_pkg::*;

    localparam logic [SCR_DIM_W-1:0] WIDTH_C  = SCR_DIM_W'(SCREEN_WIDTH);
    localparam logic [SCR_DIM_W-1:0] HEIGHT_C = SCR_DIM_W'(SCREEN_HEIGHT);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    vert_t              va_x_reg, va_y_reg;
    vert_t              vb_x_reg, vb_y_reg;
    vert_t              vc_x_reg, vc_y_reg;
    logic [COLOR_W-1:0] fill_color_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_x_reg       <= '0;
            va_y_reg       <= '0;
            vb_x_reg       <= '0;
            vb_y_reg       <= '0;
            vc_x_reg       <= '0;
            vc_y_reg       <= '0;
            fill_color_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_VERTEX_A_X: va_x_reg       <= cfg.data[VERT_W-1:0];
                REG_VERTEX_A_Y: va_y_reg       <= cfg.data[VERT_W-1:0];
                REG_VERTEX_B_X: vb_x_reg       <= cfg.data[VERT_W-1:0];
                REG_VERTEX_B_Y: vb_y_reg       <= cfg.data[VERT_W-1:0];
                REG_VERTEX_C_X: vc_x_reg       <= cfg.data[VERT_W-1:0];
                REG_VERTEX_C_Y: vc_y_reg       <= cfg.data[VERT_W-1:0];
                REG_FILL_COLOR: fill_color_reg <= cfg.data[COLOR_W-1:0];
                default:        ;   // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || result.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pixel.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pixel.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: coordinate differences and screen bounds
    // ------------------------------------------------------------------------
    diff_t x_s, y_s;
    diff_t ax_e, ay_e, bx_e, by_e, cx_e, cy_e;

    assign x_s  = {{(DIFF_W-PIX_X_W){1'b0}}, pixel.pixel_x};
    assign y_s  = {{(DIFF_W-PIX_Y_W){1'b0}}, pixel.pixel_y};
    assign ax_e = {va_x_reg[VERT_W-1], va_x_reg};
    assign ay_e = {va_y_reg[VERT_W-1], va_y_reg};
    assign bx_e = {vb_x_reg[VERT_W-1], vb_x_reg};
    assign by_e = {vb_y_reg[VERT_W-1], vb_y_reg};
    assign cx_e = {vc_x_reg[VERT_W-1], vc_x_reg};
    assign cy_e = {vc_y_reg[VERT_W-1], vc_y_reg};

    diff_t              dxa_s1_reg, dya_s1_reg, dxc_s1_reg, dyc_s1_reg;
    diff_t              ex1_s1_reg, ey1_s1_reg;
    diff_t              ex2_s1_reg, ey2_s1_reg;
    diff_t              ex3_s1_reg, ey3_s1_reg;
    logic [PIX_X_W-1:0] x_s1_reg;
    logic [PIX_Y_W-1:0] y_s1_reg;
    logic               on_s1_reg;

    always_ff @(posedge clk)
    begin
        if (en1 && pixel.valid)
        begin
            // pixel relative to the start vertex of each edge (a or c)
            dxa_s1_reg <= x_s - ax_e;
            dya_s1_reg <= y_s - ay_e;
            dxc_s1_reg <= x_s - cx_e;
            dyc_s1_reg <= y_s - cy_e;
            // edge directions: a->b, c->b, a->c
            ex1_s1_reg <= bx_e - ax_e;
            ey1_s1_reg <= by_e - ay_e;
            ex2_s1_reg <= bx_e - cx_e;
            ey2_s1_reg <= by_e - cy_e;
            ex3_s1_reg <= cx_e - ax_e;
            ey3_s1_reg <= cy_e - ay_e;
            x_s1_reg   <= pixel.pixel_x;
            y_s1_reg   <= pixel.pixel_y;
            on_s1_reg  <= ({1'b0, pixel.pixel_x} < WIDTH_C)
                       && ({2'b00, pixel.pixel_y} < HEIGHT_C);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: cross-product terms and row base address
    // ------------------------------------------------------------------------
    logic [PIX_Y_W+SCR_DIM_W-1:0] row_base;

    assign row_base = y_s1_reg * WIDTH_C;

    prod_t              p1a_s2_reg, p1b_s2_reg;
    prod_t              p2a_s2_reg, p2b_s2_reg;
    prod_t              p3a_s2_reg, p3b_s2_reg;
    prod_t              oa_s2_reg, ob_s2_reg;
    logic [ADDR_W-1:0]  row_s2_reg;
    logic [PIX_X_W-1:0] x_s2_reg;
    logic               on_s2_reg;

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            p1a_s2_reg <= ex1_s1_reg * dya_s1_reg;
            p1b_s2_reg <= ey1_s1_reg * dxa_s1_reg;
            p2a_s2_reg <= ex2_s1_reg * dyc_s1_reg;
            p2b_s2_reg <= ey2_s1_reg * dxc_s1_reg;
            p3a_s2_reg <= ex3_s1_reg * dya_s1_reg;
            p3b_s2_reg <= ey3_s1_reg * dxa_s1_reg;
            // triangle orientation (b-a) x (c-a)
            oa_s2_reg  <= ex1_s1_reg * ey3_s1_reg;
            ob_s2_reg  <= ey1_s1_reg * ex3_s1_reg;
            row_s2_reg <= row_base[ADDR_W-1:0];
            x_s2_reg   <= x_s1_reg;
            on_s2_reg  <= on_s1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: edge values reduced to sign flags, address sum
    // ------------------------------------------------------------------------
    edge_t f1, f2, f3, orient;

    assign f1     = EDGE_W'(p1a_s2_reg) - EDGE_W'(p1b_s2_reg);
    assign f2     = EDGE_W'(p2a_s2_reg) - EDGE_W'(p2b_s2_reg);
    assign f3     = EDGE_W'(p3a_s2_reg) - EDGE_W'(p3b_s2_reg);
    assign orient = EDGE_W'(oa_s2_reg)  - EDGE_W'(ob_s2_reg);

    edge_sign_t        f1_s3_reg, f2_s3_reg, f3_s3_reg, o_s3_reg;
    logic [ADDR_W-1:0] addr_s3_reg;
    logic              on_s3_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            f1_s3_reg   <= '{neg: f1[EDGE_W-1],     nz: |f1};
            f2_s3_reg   <= '{neg: f2[EDGE_W-1],     nz: |f2};
            f3_s3_reg   <= '{neg: f3[EDGE_W-1],     nz: |f3};
            o_s3_reg    <= '{neg: orient[EDGE_W-1], nz: |orient};
            addr_s3_reg <= row_s2_reg + {{(ADDR_W-PIX_X_W){1'b0}}, x_s2_reg};
            on_s3_reg   <= on_s2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: coverage decision into the output register
    // ------------------------------------------------------------------------
    logic covered;

    assign covered = on_s3_reg && o_s3_reg.nz
                  && f1_s3_reg.nz && f2_s3_reg.nz && f3_s3_reg.nz
                  && (f1_s3_reg.neg == o_s3_reg.neg)
                  && (f2_s3_reg.neg != o_s3_reg.neg)
                  && (f3_s3_reg.neg != o_s3_reg.neg);

    logic               we_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] color_reg;

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            we_reg    <= covered;
            addr_reg  <= addr_s3_reg;
            color_reg <= fill_color_reg;
        end
    end

    assign result.valid         = v4_reg;
    assign result.write_enable  = we_reg;
    assign result.pixel_address = addr_reg;
    assign result.pixel_color   = color_reg;

`ifndef SYNTHESIS
    // Input backs up only when every stage is full and the sink stalls
    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (v1_reg && v2_reg && v3_reg && result.valid && !result.ready))
        else $error("pixel input stalled with room in the pipeline");

    // With a ready sink an accepted beat reaches the output once it has passed every stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) ##1 result.ready ##1 result.ready ##1 result.ready
        |=> result.valid)
        else $error("accepted pixel did not reach the output");

    // A pixel right of the screen never draws
    a_offscreen_no_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready && ({1'b0, pixel.pixel_x} >= WIDTH_C))
        ##1 result.ready ##1 result.ready ##1 result.ready
        |=> (result.valid && !result.write_enable))
        else $error("off-screen pixel drew");
`endif

endmodule

// ===== tb/sv/tb_triangle_edge_function_rasterizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_edge_function_rasterizer: self-checking bench for the rasterizer
// Programs triangles through the configuration channel, streams pixel beats
// and compares every framebuffer write against an in-bench coverage predictor.
// Random idling on both channels, a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_triangle_edge_function_rasterizer;
    import tefr_pkg::*;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PIPE_LATENCY  = 4;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_PIXELS  = 44;

    // Index 7 is not a register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic               write_enable;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
    } fb_write_t;

    logic clk;
    logic rst_n;

    tefr_cfg_if    cfg_ch ();
    tefr_pixel_if  pix_ch ();
    tefr_result_if res_ch ();

    triangle_edge_function_rasterizer #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .pixel  (pix_ch),
        .result (res_ch)
    );

    // Shadow copy of the configuration registers
    vert_t              vtx_ax, vtx_ay, vtx_bx, vtx_by, vtx_cx, vtx_cy;
    logic [COLOR_W-1:0] fill_rgb;

    // Framebuffer writes still owed by the block, oldest first
    fb_write_t pending_writes[$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_req;
    int hold_left;
    int cycle_count;
    int error_count;
    int beats_sent;
    int drawn_count;
    int triangles_set;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Coverage predictor
    // ------------------------------------------------------------------------
    function automatic longint half_space(longint px, longint py, longint qx,
                                          longint qy, longint x, longint y);
        return (qy - py) * x + (px - qx) * y + (qx * py - px * qy);
    endfunction

    function automatic int sign3(longint v);
        if (v > 0)
            return 1;
        else if (v < 0)
            return -1;
        return 0;
    endfunction

    function automatic fb_write_t predict_fb_write(logic [PIX_X_W-1:0] px,
                                                   logic [PIX_Y_W-1:0] py);
        fb_write_t w;
        longint    ax, ay, bx, by, cx, cy, x, y;
        int        s_ab, s_cb, s_ac;
        logic      covered;
        logic      on_screen;
        ax = vtx_ax; ay = vtx_ay;
        bx = vtx_bx; by = vtx_by;
        cx = vtx_cx; cy = vtx_cy;
        x  = px;
        y  = py;
        // Inside sign of each side is its value at the opposite vertex
        s_ab = sign3(half_space(ax, ay, bx, by, cx, cy));
        s_cb = sign3(half_space(cx, cy, bx, by, ax, ay));
        s_ac = sign3(half_space(ax, ay, cx, cy, bx, by));
        covered = (s_ab != 0) && (s_cb != 0) && (s_ac != 0)
                  && (sign3(half_space(ax, ay, bx, by, x, y)) == s_ab)
                  && (sign3(half_space(cx, cy, bx, by, x, y)) == s_cb)
                  && (sign3(half_space(ax, ay, cx, cy, x, y)) == s_ac);
        on_screen = (x < SCREEN_WIDTH) && (y < SCREEN_HEIGHT);
        w.write_enable  = covered && on_screen;
        w.pixel_address = ADDR_W'(y * SCREEN_WIDTH + x);
        w.pixel_color   = fill_rgb;
        return w;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_VERTEX_A_X: vtx_ax = vert_t'(data[VERT_W-1:0]);
            REG_VERTEX_A_Y: vtx_ay = vert_t'(data[VERT_W-1:0]);
            REG_VERTEX_B_X: vtx_bx = vert_t'(data[VERT_W-1:0]);
            REG_VERTEX_B_Y: vtx_by = vert_t'(data[VERT_W-1:0]);
            REG_VERTEX_C_X: vtx_cx = vert_t'(data[VERT_W-1:0]);
            REG_VERTEX_C_Y: vtx_cy = vert_t'(data[VERT_W-1:0]);
            REG_FILL_COLOR: fill_rgb = data[COLOR_W-1:0];
            default: ;
        endcase
    endfunction

    // Vertex word with random junk above the 12 coordinate bits
    function automatic logic [CFG_DATA_W-1:0] vertex_word(int v);
        logic [CFG_DATA_W-1:0] w;
        w = $urandom;
        w[VERT_W-1:0] = v[VERT_W-1:0];
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Send one pixel beat; valid stays high on return so back-to-back beats
    // never see valid dropped and raised in the same step.
    task automatic send_pixel(int x, int y);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid   <= 1'b1;
        pix_ch.pixel_x <= PIX_X_W'(x);
        pix_ch.pixel_y <= PIX_Y_W'(y);
        do
            @(posedge clk);
        while (!pix_ch.ready);
        pending_writes.push_back(predict_fb_write(PIX_X_W'(x), PIX_Y_W'(y)));
        beats_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every owed write, then let the pipe settle
    task automatic drain_pipe();
        pix_ch.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (2 * PIPE_LATENCY) @(negedge clk);
    endtask

    // Write one register; valid is left high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg_write(idx, data);
        @(negedge clk);
    endtask

    // Program a whole triangle and color; only called with the pipe drained
    task automatic program_triangle(int ax, int ay, int bx, int by, int cx, int cy,
                                    logic [COLOR_W-1:0] color);
        write_reg(REG_VERTEX_A_X, vertex_word(ax));
        write_reg(REG_VERTEX_A_Y, vertex_word(ay));
        write_reg(REG_VERTEX_B_X, vertex_word(bx));
        write_reg(REG_VERTEX_B_Y, vertex_word(by));
        write_reg(REG_VERTEX_C_X, vertex_word(cx));
        write_reg(REG_VERTEX_C_Y, vertex_word(cy));
        write_reg(REG_FILL_COLOR, color);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        triangles_set++;
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stalls, plus a hold-off counted here on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= rst_n && ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Checker: compare each accepted result beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        fb_write_t exp_w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected result beat we=%0b addr=%0d color=%08h", $time,
                         res_ch.write_enable, res_ch.pixel_address, res_ch.pixel_color);
                error_count++;
            end
            else
            begin
                exp_w = pending_writes.pop_front();
                if (res_ch.write_enable !== exp_w.write_enable)
                begin
                    $display("%0t: write_enable mismatch at addr %0d: expected %0b, actual %0b",
                             $time, exp_w.pixel_address, exp_w.write_enable,
                             res_ch.write_enable);
                    error_count++;
                end
                if (res_ch.pixel_address !== exp_w.pixel_address)
                begin
                    $display("%0t: pixel_address mismatch: expected %0d, actual %0d",
                             $time, exp_w.pixel_address, res_ch.pixel_address);
                    error_count++;
                end
                if (res_ch.pixel_color !== exp_w.pixel_color)
                begin
                    $display("%0t: pixel_color mismatch: expected %08h, actual %08h",
                             $time, exp_w.pixel_color, res_ch.pixel_color);
                    error_count++;
                end
                if (exp_w.write_enable)
                    drawn_count++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d writes still owed", $time, pending_writes.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers give a point triangle: nothing draws, color is zero
    task automatic test_reset_state();
        send_pixel(0, 0);
        send_pixel(799, 479);
        send_pixel(1023, 511);
        drain_pipe();
    endtask

    // Same triangle in both windings; probe inside, edges, vertex, off screen
    task automatic test_winding_and_edges();
        program_triangle(100, 100, 700, 100, 400, 460, 32'hA5A5_5A5A);
        send_pixel(400, 250);   // interior
        send_pixel(400, 100);   // on side a-b
        send_pixel(250, 280);   // on side a-c
        send_pixel(550, 280);   // on side c-b
        send_pixel(700, 100);   // vertex
        send_pixel(50, 300);    // outside
        send_pixel(1023, 511);  // beyond the screen
        drain_pipe();
        program_triangle(100, 100, 400, 460, 700, 100, 32'hFFFF_FFFF);
        send_pixel(400, 250);
        send_pixel(401, 251);
        send_pixel(400, 100);
        drain_pipe();
    endtask

    // Vertices at the coordinate limits, off-screen coverage, collinear set,
    // and a write to the unused register index
    task automatic test_extreme_vertices();
        program_triangle(-2048, -2048, 2047, -2048, 0, 2047, 32'h0000_0001);
        send_pixel(0, 0);       // covered
        send_pixel(500, 479);   // covered, last row
        send_pixel(900, 100);   // covered but past the last column
        send_pixel(500, 500);   // covered but past the last row
        send_pixel(799, 479);   // outside side c-b
        drain_pipe();
        program_triangle(2047, 2047, -2048, 2047, -2048, -2048, 32'h8000_0000);
        send_pixel(10, 479);
        send_pixel(799, 0);
        drain_pipe();
        // Collinear vertices draw nothing, even on the line itself
        program_triangle(-2048, -2048, 0, 0, 2047, 2047, 32'h1234_5678);
        send_pixel(100, 100);
        send_pixel(100, 50);
        send_pixel(50, 100);
        drain_pipe();
        // Index 7 is ignored; the shadow registers stay put
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        send_pixel(100, 50);
        drain_pipe();
    endtask

    // Random triangles, each followed by a burst of pixels, mostly in its
    // bounding box so both sides of every edge are hit
    task automatic test_random_triangles();
        int ax, ay, bx, by, cx, cy;
        int x_lo, x_hi, y_lo, y_hi;
        int kind;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            // Hold one phase with no idling on either side
            src_idle_pct  = (ph == 4) ? 0 : 34;
            sink_idle_pct = (ph == 4) ? 0 : 34;
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                ax = $urandom_range(0, 4095) - 2048;
                ay = $urandom_range(0, 4095) - 2048;
                bx = $urandom_range(0, 4095) - 2048;
                by = $urandom_range(0, 4095) - 2048;
                cx = $urandom_range(0, 4095) - 2048;
                cy = $urandom_range(0, 4095) - 2048;
            end
            else
            begin
                ax = $urandom_range(0, 1200) - 200;
                ay = $urandom_range(0, 800) - 150;
                bx = $urandom_range(0, 1200) - 200;
                by = $urandom_range(0, 800) - 150;
                cx = $urandom_range(0, 1200) - 200;
                cy = $urandom_range(0, 800) - 150;
            end
            if (kind == 9)
            begin
                // Degenerate: reflect a through b, or repeat a
                cx = 2 * bx - ax;
                cy = 2 * by - ay;
                if (cx < -2048 || cx > 2047 || cy < -2048 || cy > 2047)
                begin
                    cx = ax;
                    cy = ay;
                end
            end
            program_triangle(ax, ay, bx, by, cx, cy, $urandom);
            x_lo = (ax < bx) ? ax : bx;  x_lo = (cx < x_lo) ? cx : x_lo;
            x_hi = (ax > bx) ? ax : bx;  x_hi = (cx > x_hi) ? cx : x_hi;
            y_lo = (ay < by) ? ay : by;  y_lo = (cy < y_lo) ? cy : y_lo;
            y_hi = (ay > by) ? ay : by;  y_hi = (cy > y_hi) ? cy : y_hi;
            x_lo = (x_lo < 0) ? 0 : x_lo;
            y_lo = (y_lo < 0) ? 0 : y_lo;
            x_hi = (x_hi > 1023) ? 1023 : x_hi;
            y_hi = (y_hi > 511) ? 511 : y_hi;
            if (x_lo > x_hi)
            begin
                x_lo = 0;
                x_hi = 1023;
            end
            if (y_lo > y_hi)
            begin
                y_lo = 0;
                y_hi = 511;
            end
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                if ($urandom_range(0, 99) < 75)
                    send_pixel($urandom_range(x_lo, x_hi), $urandom_range(y_lo, y_hi));
                else
                    send_pixel($urandom_range(0, 1023), $urandom_range(0, 511));
            end
            drain_pipe();
        end
        src_idle_pct  = 34;
        sink_idle_pct = 34;
    endtask

    // Hold the output off for a long stretch while pixels keep coming, so
    // the pipe fills and stalls its input; then pause until drained
    task automatic test_output_backpressure();
        program_triangle(0, 0, 799, 0, 0, 479, 32'hC0FF_EE00);
        src_idle_pct = 0;
        @(posedge clk);
        hold_req = 300;
        @(negedge clk);
        for (int i = 0; i < 40; i++)
            send_pixel($urandom_range(0, 1023), $urandom_range(0, 511));
        src_idle_pct = 34;
        drain_pipe();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        pix_ch.valid   = 1'b0;
        pix_ch.pixel_x = '0;
        pix_ch.pixel_y = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        res_ch.ready   = 1'b0;
        vtx_ax = '0; vtx_ay = '0;
        vtx_bx = '0; vtx_by = '0;
        vtx_cx = '0; vtx_cy = '0;
        fill_rgb      = '0;
        src_idle_pct  = 34;
        sink_idle_pct = 34;
        hold_req      = 0;
        hold_left     = 0;
        cycle_count   = 0;
        error_count   = 0;
        beats_sent    = 0;
        drawn_count   = 0;
        triangles_set = 0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_winding_and_edges();
        test_extreme_vertices();
        test_random_triangles();
        test_output_backpressure();

        // Owed writes are gone; watch a while longer for stray beats
        drain_pipe();
        repeat (4 * PIPE_LATENCY) @(posedge clk);

        $display("Ran %0d triangles and %0d pixel beats, %0d of them drawn;", triangles_set,
                 beats_sent, drawn_count);
        $display("windings, edges, degenerate, off-screen and output hold-off all exercised.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tefr_pkg.sv
design/tefr_channels.sv
design/triangle_edge_function_rasterizer.sv
tb/sv/tb_triangle_edge_function_rasterizer.sv
